@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, no reset qualification
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

// concurrent check, disabled while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`endif

@@ rtl/core/pfc_pkg.sv @@
// ---------------------------------------------------------------------------
// pfc_pkg
// types, constants and helpers of the pixel format converter
// ---------------------------------------------------------------------------
package pfc_pkg;

   // palette sizing
   localparam int PALETTE_ENTRIES_DEFAULT = 256;
   localparam int PAL_INDEX_W             = 8;
   localparam int PAL_COLOR_W             = 24;

   // pixel widths
   localparam int PIXEL_W = 32;
   localparam int RGB565_W = 16;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONVERSION      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_THRESHOLD = 1'b1;

   // fixed values
   localparam logic [7:0]          ALPHA_OPAQUE      = 8'hFF;
   localparam logic [RGB565_W-1:0] DARK_565          = 16'h0821;
   localparam logic [7:0]          THRESHOLD_RESET   = 8'd30;
   localparam logic [7:0]          DARK_LIMIT        = 8'd16;

   // conversion select
   typedef enum logic [1:0] {
      CONV_ARGB_TO_565  = 2'd0,
      CONV_565_TO_ARGB  = 2'd1,
      CONV_INDEX_TO_ARGB = 2'd2,
      CONV_INDEX_TO_565 = 2'd3
   } conv_type;

   // configuration registers as seen by the datapath
   typedef struct packed {
      conv_type   conversion;
      logic [7:0] alpha_threshold;
   } cfg_type;

   // palette access issued by the first stage
   typedef struct packed {
      logic                   wr_en;
      logic [PAL_INDEX_W-1:0] wr_index;
      logic [PAL_COLOR_W-1:0] wr_color;
      logic [PAL_INDEX_W-1:0] rd_index;
   } pal_req_type;

   // truncate three 8-bit channels and pack as rgb565
   function automatic logic [RGB565_W-1:0] pack_565(input logic [7:0] r,
                                                    input logic [7:0] g,
                                                    input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

@@ rtl/core/pfc_palette.sv @@
// ---------------------------------------------------------------------------
// pfc_palette
// palette store, one write and one registered read per advancing cycle
// ---------------------------------------------------------------------------
module pfc_palette
   import pfc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   advance,
   input  pal_req_type            pal_req,
   output logic [PAL_COLOR_W-1:0] rd_color,
   output logic                   rd_hit
);

   localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   logic [PAL_COLOR_W-1:0] mem [PALETTE_ENTRIES];
   logic [PAL_COLOR_W-1:0] rd_color_ff;
   logic                   rd_hit_ff;
   logic                   wr_hit;
   logic                   rd_hit_in;

   // indexes at or above the store depth are dropped on write, flagged as a miss on read
   assign wr_hit    = {1'b0, pal_req.wr_index} < (PAL_INDEX_W+1)'(PALETTE_ENTRIES);
   assign rd_hit_in = {1'b0, pal_req.rd_index} < (PAL_INDEX_W+1)'(PALETTE_ENTRIES);

   // write port
   always_ff @(posedge clock) begin
      if (advance && pal_req.wr_en && wr_hit) begin
         mem[pal_req.wr_index[IDX_W-1:0]] <= pal_req.wr_color;
      end
   end

   // registered read port, holds while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         rd_color_ff <= mem[pal_req.rd_index[IDX_W-1:0]];
         rd_hit_ff   <= rd_hit_in;
      end
   end

   assign rd_color = rd_color_ff;
   assign rd_hit   = rd_hit_ff;

endmodule

@@ rtl/core/pfc_format.sv @@
// ---------------------------------------------------------------------------
// pfc_format
// final format selection: rgb565 packing, argb expansion, palette output
// ---------------------------------------------------------------------------
module pfc_format
   import pfc_pkg::*;
(
   input  cfg_type                cfg,
   input  logic [PIXEL_W-1:0]     pixel,
   input  logic [PAL_COLOR_W-1:0] entry,
   input  logic                   entry_hit,
   output logic [PIXEL_W-1:0]     pixel_out
);

   logic [7:0]             a;
   logic [7:0]             r;
   logic [7:0]             g;
   logic [7:0]             b;
   logic [RGB565_W-1:0]    c;
   logic [PAL_COLOR_W-1:0] e;
   logic                   dark;

   assign a = pixel[31:24];
   assign r = pixel[23:16];
   assign g = pixel[15:8];
   assign b = pixel[7:0];
   assign c = pixel[RGB565_W-1:0];

   // out-of-range palette lookups read as black
   assign e = entry_hit ? entry : '0;

   assign dark = (r < DARK_LIMIT) && (g < DARK_LIMIT) && (b < DARK_LIMIT)
                 && (pixel != '0);

   // select the conversion
   always_comb begin
      pixel_out = '0;
      case (cfg.conversion)
         CONV_ARGB_TO_565: begin
            if (a <= cfg.alpha_threshold) begin
               pixel_out = '0;
            end else if (dark) begin
               pixel_out = {16'h0000, DARK_565};
            end else begin
               pixel_out = {16'h0000, pack_565(r, g, b)};
            end
         end
         CONV_565_TO_ARGB: begin
            pixel_out = {ALPHA_OPAQUE, c[15:11], 3'b000, c[10:5], 2'b00,
                         c[4:0], 3'b000};
         end
         CONV_INDEX_TO_ARGB: begin
            pixel_out = {ALPHA_OPAQUE, e};
         end
         default: begin
            pixel_out = {16'h0000, pack_565(e[23:16], e[15:8], e[7:0])};
         end
      endcase
   end

endmodule

@@ rtl/core/pixel_format_converter_core.sv @@
// ---------------------------------------------------------------------------
// pixel_format_converter_core
// streaming pixel format converter with palette lookup
// ---------------------------------------------------------------------------
// Accepts one item per clock while req_stall is low and passes each converted
// pixel through an input register, the palette read register and the
// output register. Palette-write items (mode 1) take a slot in the pipeline
// but give no result. The whole pipeline advances together; when a result
// waits on rsp_stall, req_stall rises in the same cycle. Palette entries hold
// no defined value until written and are not cleared after reset.
module pixel_format_converter_core
   import pfc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // input items
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_mode,
   input  logic [PIXEL_W-1:0]     req_pixel_in,
   input  logic [PAL_INDEX_W-1:0] req_palette_index,
   input  logic [PAL_COLOR_W-1:0] req_palette_color,
   // result items
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIXEL_W-1:0]     rsp_pixel_out,
   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type                cfg_ff,  cfg_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_mode_ff;
   logic [PIXEL_W-1:0]     s1_pixel_ff;
   logic [PAL_INDEX_W-1:0] s1_index_ff;
   logic [PAL_COLOR_W-1:0] s1_color_ff;
   logic                   s2_valid_ff, s2_valid_in;
   logic [PIXEL_W-1:0]     s2_pixel_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]     rsp_pixel_ff, rsp_pixel_in;
   logic                   advance;
   pal_req_type            pal_req;
   logic [PAL_COLOR_W-1:0] pal_color;
   logic                   pal_hit;

   // pipeline moves whenever the output slot is free or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // configuration register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CONVERSION:      cfg_in.conversion      = conv_type'(csr_wdata[1:0]);
            CSR_ALPHA_THRESHOLD: cfg_in.alpha_threshold = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conversion      <= CONV_ARGB_TO_565;
         cfg_ff.alpha_threshold <= THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // valid bits, palette writes drop out after the palette stage
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s2_valid_in  = s2_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         s1_valid_in  = req_valid;
         s2_valid_in  = s1_valid_ff && !s1_mode_ff;
         rsp_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage 1: input register
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mode_ff  <= req_mode;
         s1_pixel_ff <= req_pixel_in;
         s1_index_ff <= req_palette_index;
         s1_color_ff <= req_palette_color;
      end
   end

   // stage 2: palette access, pixel carried alongside the read data
   assign pal_req.wr_en    = s1_valid_ff && s1_mode_ff;
   assign pal_req.wr_index = s1_index_ff;
   assign pal_req.wr_color = s1_color_ff;
   assign pal_req.rd_index = s1_pixel_ff[PAL_INDEX_W-1:0];

   pfc_palette #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_palette (
      .clock    (clock),
      .advance  (advance),
      .pal_req  (pal_req),
      .rd_color (pal_color),
      .rd_hit   (pal_hit)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_pixel_ff <= s1_pixel_ff;
      end
   end

   // stage 3: format and output register
   pfc_format u_format (
      .cfg       (cfg_ff),
      .pixel     (s2_pixel_ff),
      .entry     (pal_color),
      .entry_hit (pal_hit),
      .pixel_out (rsp_pixel_in)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pixel_ff <= rsp_pixel_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

endmodule

@@ rtl/core/pfc_checker.sv @@
// ---------------------------------------------------------------------------
// pfc_checker
// port-level checks of the pixel format converter core
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pfc_checker
   import pfc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_mode,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [PIXEL_W-1:0] rsp_pixel_out
);

   // no result straight out of reset
   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // input backs up only behind a waiting result
   `ASSERT_CLK_RST(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "input stalled without a waiting result")

   // a converted item that meets no output stall on the way arrives as a valid result
   `ASSERT_CLK_RST(a_latency, clock, reset, (req_valid && !req_stall && !req_mode) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid, "converted item did not arrive")

   // a waiting result holds
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pixel_out)), "stalled result changed")

endmodule

bind pixel_format_converter_core pfc_checker u_pfc_checker (.*);

@@ dv/pixel_format_converter_core_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pixel_format_converter_core_tb
// streaming check of the pixel format converter
// ---------------------------------------------------------------------------
// Drives pixel and palette-write items through the core under each of the
// four conversions and several alpha thresholds. A scoreboard keeps its own
// palette and register copies, predicts every converted pixel in order and
// compares it with what leaves the core. Both sides idle at random, one
// stretch runs without idling, the receiver once holds off long enough to
// back the core up, and the sender drains the core between settings.
// ---------------------------------------------------------------------------
module pixel_format_converter_core_tb;
   import pfc_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES  = 60;
   localparam int IDLE_PERCENT = 31;

   // scoreboard: palette and register copies, expected pixels in order
   class pixel_scoreboard;
      logic [PAL_COLOR_W-1:0] palette [256];
      bit                     written [256];
      logic [PAL_INDEX_W-1:0] written_list [$];
      conv_type               conversion;
      logic [7:0]             alpha_threshold;
      logic [PIXEL_W-1:0]     expected_pixels [$];
      int                     errors;
      int                     items_seen;
      int                     palette_writes;
      int                     results_checked;

      function new();
         conversion      = CONV_ARGB_TO_565;
         alpha_threshold = THRESHOLD_RESET;
         errors          = 0;
         items_seen      = 0;
         palette_writes  = 0;
         results_checked = 0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      function void set_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_CONVERSION)
            conversion = conv_type'(data[1:0]);
         else
            alpha_threshold = data;
      endfunction

      // converted value of one pixel under the current settings
      function logic [PIXEL_W-1:0] convert_pixel(input logic [PIXEL_W-1:0] px);
         logic [7:0]             a, r, g, b;
         logic [PAL_COLOR_W-1:0] entry;
         logic [PIXEL_W-1:0]     res;
         a     = px[31:24];
         r     = px[23:16];
         g     = px[15:8];
         b     = px[7:0];
         entry = palette[px[7:0]];
         case (conversion)
            CONV_ARGB_TO_565: begin
               if (a <= alpha_threshold)
                  res = '0;
               else if (r < DARK_LIMIT && g < DARK_LIMIT && b < DARK_LIMIT && px != '0)
                  res = {16'h0000, DARK_565};
               else
                  res = {16'h0000, r[7:3], g[7:2], b[7:3]};
            end
            CONV_565_TO_ARGB: begin
               res = {ALPHA_OPAQUE, px[15:11], 3'b000, px[10:5], 2'b00, px[4:0], 3'b000};
            end
            CONV_INDEX_TO_ARGB: begin
               res = {ALPHA_OPAQUE, entry};
            end
            default: begin
               res = {16'h0000, entry[23:19], entry[15:10], entry[7:3]};
            end
         endcase
         return res;
      endfunction

      function void note_input(input logic mode, input logic [PIXEL_W-1:0] px,
                               input logic [PAL_INDEX_W-1:0] pidx,
                               input logic [PAL_COLOR_W-1:0] pcol);
         items_seen++;
         if (mode) begin
            palette_writes++;
            palette[pidx] = pcol;
            if (!written[pidx]) written_list.push_back(pidx);
            written[pidx] = 1'b1;
         end else begin
            expected_pixels.push_back(convert_pixel(px));
         end
      endfunction

      function void check_result(input logic [PIXEL_W-1:0] actual);
         logic [PIXEL_W-1:0] want;
         if (expected_pixels.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result item: got %h", actual);
         end else begin
            want = expected_pixels.pop_front();
            results_checked++;
            if (actual !== want) begin
               errors++;
               if (errors <= 10)
                  $display("pixel_out mismatch: expected %h got %h", want, actual);
            end
         end
      endfunction

      function int outstanding();
         return expected_pixels.size();
      endfunction

      // any palette entry already loaded
      function logic [PAL_INDEX_W-1:0] pick_written_index();
         return written_list[$urandom_range(0, written_list.size() - 1)];
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_mode;
   logic [PIXEL_W-1:0]     req_pixel_in;
   logic [PAL_INDEX_W-1:0] req_palette_index;
   logic [PAL_COLOR_W-1:0] req_palette_color;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [PIXEL_W-1:0]     rsp_pixel_out;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   pixel_scoreboard sb;
   bit              idle_on;
   bit              hold_request;
   int              cycle_count;

   pixel_format_converter_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_pixel_in      (req_pixel_in),
      .req_palette_index (req_palette_index),
      .req_palette_color (req_palette_color),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_out     (rsp_pixel_out),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", CYCLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: random stalls, one long hold on request
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   // compare each accepted result
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_pixel_out);
   end

   // offer one item, return at the falling edge after it is taken
   task automatic send_item(input logic mode, input logic [PIXEL_W-1:0] px,
                            input logic [PAL_INDEX_W-1:0] pidx,
                            input logic [PAL_COLOR_W-1:0] pcol);
      while (idle_on && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_pixel_in      <= px;
      req_palette_index <= pidx;
      req_palette_color <= pcol;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(mode, px, pidx, pcol);
      @(negedge clock);
   endtask

   // wait until every pixel is back and any trailing palette write has landed
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_register(idx, data);
   endtask

   // source pixel aimed at the interesting parts of each conversion
   function automatic logic [PIXEL_W-1:0] random_pixel(input conv_type conv,
                                                       input logic [7:0] thr);
      logic [PIXEL_W-1:0] px;
      logic [7:0]         a;
      int                 pick;
      px   = $urandom();
      pick = $urandom_range(0, 9);
      case (conv) inside
         CONV_ARGB_TO_565: begin
            if (pick < 2) begin
               // dark pixel region
               px[23:20] = 4'h0;
               px[15:12] = 4'h0;
               px[7:4]   = 4'h0;
            end else if (pick < 4) begin
               // alpha right around the threshold
               case ($urandom_range(0, 2))
                  0:       a = (thr == 8'h00) ? thr : thr - 8'd1;
                  1:       a = thr;
                  default: a = (thr == 8'hFF) ? thr : thr + 8'd1;
               endcase
               px[31:24] = a;
            end
         end
         CONV_INDEX_TO_ARGB, CONV_INDEX_TO_565: begin
            px[7:0] = sb.pick_written_index();
         end
         default: ;
      endcase
      return px;
   endfunction

   task automatic run_phase(input conv_type conv, input logic [7:0] thr,
                            input int count, input bit idle, input bit with_hold);
      logic [PIXEL_W-1:0] px;
      drain();
      write_register(CSR_CONVERSION, {6'b000000, conv});
      write_register(CSR_ALPHA_THRESHOLD, thr);
      idle_on = idle;
      for (int n = 0; n < count; n++) begin
         if (with_hold && n == 10) hold_request = 1'b1;
         px = random_pixel(conv, thr);
         if ($urandom_range(0, 99) < 20)
            send_item(1'b1, $urandom(), PAL_INDEX_W'($urandom()),
                      PAL_COLOR_W'($urandom()));
         else
            send_item(1'b0, px, PAL_INDEX_W'($urandom()), PAL_COLOR_W'($urandom()));
      end
      idle_on = 1'b1;
   endtask

   initial begin : stimulus
      int failures;
      sb                = new();
      idle_on           = 1'b1;
      hold_request      = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_mode          = 1'b0;
      req_pixel_in      = '0;
      req_palette_index = '0;
      req_palette_color = '0;
      csr_we            = 1'b0;
      csr_index         = CSR_CONVERSION;
      csr_wdata         = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // argb to rgb565 with the threshold left at its reset value
      send_item(1'b0, 32'h00000000, 8'h00, 24'h000000);
      send_item(1'b0, 32'h1E123456, 8'h00, 24'h000000);
      send_item(1'b0, 32'h1F0F0F0F, 8'h00, 24'h000000);
      send_item(1'b0, 32'hFF000000, 8'h00, 24'h000000);
      send_item(1'b0, 32'hFF0F0F10, 8'h00, 24'h000000);
      send_item(1'b0, 32'hFFFFFFFF, 8'h00, 24'h000000);
      send_item(1'b0, 32'h80F80408, 8'h00, 24'h000000);
      send_item(1'b0, 32'hFF102030, 8'hFF, 24'hFFFFFF);

      // threshold extremes
      drain();
      write_register(CSR_ALPHA_THRESHOLD, 8'hFF);
      send_item(1'b0, 32'hFFFFFFFF, 8'h00, 24'h000000);
      drain();
      write_register(CSR_ALPHA_THRESHOLD, 8'h00);
      send_item(1'b0, 32'h00FFFFFF, 8'h00, 24'h000000);
      send_item(1'b0, 32'h01000000, 8'h00, 24'h000000);

      // rgb565 to argb, upper bits ignored
      drain();
      write_register(CSR_CONVERSION, {6'b000000, CONV_565_TO_ARGB});
      send_item(1'b0, 32'h00000000, 8'h00, 24'h000000);
      send_item(1'b0, 32'h0000FFFF, 8'h00, 24'h000000);
      send_item(1'b0, 32'hFFFF0000, 8'h00, 24'h000000);
      send_item(1'b0, 32'h5A5AF81F, 8'h00, 24'h000000);

      // palette loads, pixel field ignored
      send_item(1'b1, 32'hFFFFFFFF, 8'h00, 24'h000000);
      send_item(1'b1, 32'h00000000, 8'hFF, 24'hFFFFFF);
      send_item(1'b1, 32'h12345678, 8'h5A, 24'hA5C3E1);
      send_item(1'b1, 32'h00000000, 8'h81, 24'h123456);

      // index lookups to argb and to rgb565
      drain();
      write_register(CSR_CONVERSION, {6'b000000, CONV_INDEX_TO_ARGB});
      send_item(1'b0, 32'h00000000, 8'h00, 24'h000000);
      send_item(1'b0, 32'hFFFFFFFF, 8'h00, 24'h000000);
      send_item(1'b0, 32'hABCDEF5A, 8'h00, 24'h000000);
      send_item(1'b0, 32'h00000081, 8'h00, 24'h000000);
      drain();
      write_register(CSR_CONVERSION, {6'b000000, CONV_INDEX_TO_565});
      send_item(1'b0, 32'hFFFFFF00, 8'h00, 24'h000000);
      send_item(1'b0, 32'h000000FF, 8'h00, 24'h000000);
      send_item(1'b0, 32'h1234565A, 8'h00, 24'h000000);
      send_item(1'b0, 32'h00000081, 8'h00, 24'h000000);

      // random phases over the settings
      run_phase(CONV_ARGB_TO_565, THRESHOLD_RESET, 50, 1'b1, 1'b0);
      run_phase(CONV_ARGB_TO_565, 8'h00, 50, 1'b1, 1'b0);
      run_phase(CONV_ARGB_TO_565, 8'hFF, 30, 1'b1, 1'b0);
      run_phase(CONV_ARGB_TO_565, 8'($urandom()), 60, 1'b1, 1'b0);
      run_phase(CONV_565_TO_ARGB, 8'($urandom()), 50, 1'b0, 1'b0);
      run_phase(CONV_INDEX_TO_ARGB, 8'($urandom()), 70, 1'b1, 1'b1);
      run_phase(CONV_INDEX_TO_565, 8'($urandom()), 60, 1'b1, 1'b0);
      run_phase(CONV_INDEX_TO_ARGB, 8'hFF, 40, 1'b1, 1'b0);
      run_phase(CONV_INDEX_TO_565, 8'h00, 40, 1'b1, 1'b0);

      drain();
      failures = sb.errors + sb.outstanding();
      $display("sent %0d items (%0d palette loads), checked %0d converted pixels",
               sb.items_seen, sb.palette_writes, sb.results_checked);
      $display("all four conversions, thresholds 0, 30, 255 and random, %0d errors",
               failures);
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
